FILE: design/binary_neighbour_count_filter_top_macros.svh
// Assertion macros for the neighbour count filter checker.
// Used by bncf_checker; expects clk_i and rst_ni in scope.
`ifndef BINARY_NEIGHBOUR_COUNT_FILTER_TOP_MACROS_SVH
`define BINARY_NEIGHBOUR_COUNT_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define BNCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BNCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bncf_pkg.sv
// Shared types, constants and functions of the neighbour count filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bncf_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned LIMIT_W    = 4;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned TOTAL_W    = 21;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CLR_W      = COL_W + 1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_COUNT_LIMIT = 2'd2
  } cfg_reg_e;

  // item held between the read and the update stage
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             cur;
    logic             col_zero;
    logic             row_ge1;
    logic             row_ge2;
    logic             emit_main;
    logic             emit_row;
    logic             frame_last;
    logic             frame_end;
  } s1_item_t;

  typedef struct packed {
    logic               frame_done;
    logic               row_done;
    logic [TOTAL_W-1:0] total;
    logic [CNT_W-1:0]   count;
    logic               marked;
  } result_t;

  // 0 acts as 1, anything above the maximum as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  // neighbours of window bit 4, zero for an empty centre
  function automatic logic [CNT_W-1:0] win_count(input logic [8:0] win);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) c = c + CNT_W'(win[i]);
    end
    if (!win[4]) c = '0;
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/bncf_line_ram.sv
// Line store: two bits per column (upper line, middle line), one write
// and one registered read port. Uses bncf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bncf_line_ram import bncf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [COL_W-1:0] waddr_i,
  input  wire logic [1:0]       wdata_i,
  input  wire logic             re_i,
  input  wire logic [COL_W-1:0] raddr_i,
  output logic      [1:0]       rdata_o
);

  // bit 1: upper line, bit 0: middle line
  logic [1:0] mem_q [MAX_WIDTH];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/bncf_window.sv
// Update stage: builds the 3x3 window from the line store read, counts
// neighbours, keeps the frame total and writes the line store back. Uses bncf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bncf_window import bncf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire s1_item_t           item_i,
  input  wire logic [1:0]         line_i,
  input  wire logic [LIMIT_W-1:0] limit_i,
  output logic                    ram_we_o,
  output logic [1:0]              ram_wdata_o,
  output logic [1:0]              push_n_o,
  output result_t                 res0_o,
  output result_t                 res1_o
);

  logic [8:0]         win_q, win_d, win_base;
  logic [TOTAL_W-1:0] total_q, total_d, total_a, total_b;
  logic               top_b, mid_b;
  logic [8:0]         win_row;
  logic [CNT_W-1:0]   cnt_a, cnt_b;
  logic               mark_a, mark_b;
  result_t            res_a, res_b;

  always_comb begin
    top_b    = item_i.row_ge2 & line_i[1];
    mid_b    = item_i.row_ge1 & line_i[0];
    win_base = item_i.col_zero ? 9'd0 : win_q;
    // new right column: upper in bit 6, lower in bit 8
    win_d    = {item_i.cur, mid_b, top_b, win_base[8:3]};
    win_row  = {3'b000, win_d[8:3]};

    cnt_a  = win_count(win_d);
    cnt_b  = win_count(win_row);
    mark_a = win_d[4] & (cnt_a < limit_i);
    mark_b = win_row[4] & (cnt_b < limit_i);

    total_a = total_q;
    if (item_i.emit_main && mark_a && total_q != TOTAL_MAX) total_a = total_q + 1'b1;
    total_b = total_a;
    if (item_i.emit_row && mark_b && total_a != TOTAL_MAX) total_b = total_a + 1'b1;
    total_d = item_i.frame_end ? '0 : total_b;

    res_a = '{frame_done: 1'b0, row_done: 1'b0, total: total_a, count: cnt_a,
              marked: mark_a};
    res_b = '{frame_done: item_i.frame_last, row_done: 1'b1, total: total_b,
              count: cnt_b, marked: mark_b};

    if (item_i.emit_main) begin
      res0_o = res_a;
      res1_o = res_b;
    end else begin
      res0_o = res_b;
      res1_o = res_a;
    end
    push_n_o = fire_i ? (2'(item_i.emit_main) + 2'(item_i.emit_row)) : 2'd0;

    ram_we_o    = fire_i;
    ram_wdata_o = {line_i[0], item_i.cur};  // middle moves up, new cell in
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      total_q <= '0;
    end else if (fire_i) begin
      win_q   <= win_d;
      total_q <= total_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/bncf_out_fifo.sv
// Four-entry result queue taking up to two results a cycle and giving
// one a cycle to the output stream while it is ready. Uses bncf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bncf_out_fifo import bncf_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic [1:0] push_n_i,
  input  wire result_t res0_i,
  input  wire result_t res1_i,
  output logic         space_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      data_o
);

  result_t    mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign pop     = valid_o & ready_i;
  assign valid_o = (cnt_q != 3'd0);
  assign space_o = (cnt_q <= 3'd2);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wp_q] <= res0_i;
    if (push_n_i == 2'd2) mem_q[wp_q + 2'd1] <= res1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + push_n_i;
      rp_q  <= rp_q + 2'(pop);
      cnt_q <= cnt_q + 3'(push_n_i) - 3'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: design/binary_neighbour_count_filter_top.sv
// Channel   Dir  Width  Content (lowest bit first)
// s_axis    in   8      cell_occupied
// m_axis    out  32     cell_marked, neighbour_count, marked_total; tlast row_done,
//                       tuser frame_done
// cfg       in   11     grid_width, grid_height, count_limit by index
//
// One item a cycle enters if the queue has room; results go out one a cycle as taken.
// A row of w cells gives w results (the first row none), up to two on its last cell;
// the queue holds the extra one and the next row's first cell, which gives none,
// lets it drain, so one item a cycle is kept up when the output never stalls.
// After reset all 1024 line store columns are cleared, s_axis_tready held low.
// Output stalls back up through a four-entry queue into the update stage.
`timescale 1ns / 1ps
`default_nettype none

module binary_neighbour_count_filter_top import bncf_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [0] cell_occupied
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [0] cell_marked, [4:1] neighbour_count, [25:5] marked_total
  output logic [31:0]               m_axis_tdata,
  output logic                      m_axis_tlast,   // row_done
  output logic                      m_axis_tuser,   // [0] frame_done
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_data_i
);

  logic [DIM_W-1:0]   width_q, height_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [COL_W-1:0]   col_q, col_d, col_eff, wm1;
  logic [DIM_W-1:0]   row_q, row_d, row_eff;
  logic [CLR_W-1:0]   clr_q;
  logic               clr_busy;
  s1_item_t           s1_q, item_d;
  logic               s1_valid_q;
  logic               fwd_q;
  logic [1:0]         fwd_data_q, line, ram_rdata;
  logic               accept, fire, last, space;
  logic               upd_we, ram_we;
  logic [1:0]         upd_wdata, ram_wdata;
  logic [COL_W-1:0]   ram_waddr;
  logic [1:0]         push_n;
  result_t            res0, res1, out_res;

  assign clr_busy      = (clr_q < CLR_W'(MAX_WIDTH));
  assign fire          = s1_valid_q & space;
  assign s_axis_tready = !clr_busy && (!s1_valid_q || fire);
  assign accept        = s_axis_tvalid & s_axis_tready;

  // front end: clamp position, classify the item
  always_comb begin
    wm1     = COL_W'(width_q - 1'b1);
    col_eff = (col_q > wm1) ? wm1 : col_q;
    row_eff = (row_q > height_q) ? height_q : row_q;
    last    = (col_eff == wm1);

    item_d.col        = col_eff;
    item_d.cur        = (row_eff < height_q) & s_axis_tdata[0];
    item_d.col_zero   = (col_eff == '0);
    item_d.row_ge1    = (row_eff != '0);
    item_d.row_ge2    = (row_eff >= DIM_W'(2));
    item_d.emit_main  = item_d.row_ge1 && (col_eff != '0);
    item_d.emit_row   = last && item_d.row_ge1;
    item_d.frame_last = (row_eff == height_q);
    item_d.frame_end  = last && (row_eff == height_q);

    if (last) begin
      col_d = '0;
      row_d = (row_eff == height_q) ? '0 : row_eff + 1'b1;
    end else begin
      col_d = col_eff + 1'b1;
      row_d = row_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(MAX_WIDTH);
      height_q <= DIM_W'(MAX_HEIGHT);
      limit_q  <= LIMIT_W'(4);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_WIDTH:  width_q  <= clamp_dim(cfg_data_i, DIM_W'(MAX_WIDTH));
        REG_GRID_HEIGHT: height_q <= clamp_dim(cfg_data_i, DIM_W'(MAX_HEIGHT));
        REG_COUNT_LIMIT: limit_q  <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      clr_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (clr_busy) clr_q <= clr_q + 1'b1;
      if (accept) begin
        col_q      <= col_d;
        row_q      <= row_d;
        s1_valid_q <= 1'b1;
        // same column written back on this edge: read sees old data
        fwd_q      <= fire && (s1_q.col == col_eff);
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q       <= item_d;
      fwd_data_q <= upd_wdata;
    end
  end

  assign line = fwd_q ? fwd_data_q : ram_rdata;

  assign ram_we    = clr_busy | upd_we;
  assign ram_waddr = clr_busy ? clr_q[COL_W-1:0] : s1_q.col;
  assign ram_wdata = clr_busy ? 2'b00 : upd_wdata;

  bncf_line_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (col_eff),
    .rdata_o (ram_rdata)
  );

  bncf_window u_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (s1_q),
    .line_i      (line),
    .limit_i     (limit_q),
    .ram_we_o    (upd_we),
    .ram_wdata_o (upd_wdata),
    .push_n_o    (push_n),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  bncf_out_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .res0_i   (res0),
    .res1_i   (res1),
    .space_o  (space),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .data_o   (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.total, out_res.count, out_res.marked};
  assign m_axis_tlast = out_res.row_done;
  assign m_axis_tuser = out_res.frame_done;

endmodule

`default_nettype wire

FILE: design/bncf_checker.sv
// Port-level checks on the result stream of the neighbour count filter.
// Uses binary_neighbour_count_filter_top_macros.svh; bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_neighbour_count_filter_top_macros.svh"

module bncf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  `BNCF_ASSERT_NOW(a_frame_is_row_end, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "frame end without row end")
  `BNCF_ASSERT_NOW(a_count_range, m_axis_tvalid, m_axis_tdata[4:1] <= 4'd8, "neighbour count above eight")
  `BNCF_ASSERT_NOW(a_marked_total, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[25:5] != 21'd0, "marked item with zero total")
  `BNCF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")

endmodule

bind binary_neighbour_count_filter_top bncf_checker u_bncf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: dv/tb_binary_neighbour_count_filter_top.sv
// Self-checking bench for binary_neighbour_count_filter_top: raster cells in, marked results out.
// Predicts every result from its own line stores and window. Needs bncf_pkg and the top RTL.
`timescale 1ns / 1ps

module tb_binary_neighbour_count_filter_top;
  import bncf_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned RANDOM_CELLS  = 260;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;   // [0] cell_occupied
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [0] cell_marked, [4:1] neighbour_count, [25:5] marked_total
  logic [31:0]          m_axis_tdata;
  logic                 m_axis_tlast;        // row_done
  logic                 m_axis_tuser;        // [0] frame_done
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_GRID_WIDTH;
  logic [DIM_W-1:0]     cfg_data_i = '0;

  binary_neighbour_count_filter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bit      cell_feed[$];
  result_t due_results[$];
  bit      gaps_on;
  bit      long_hold_armed;
  int unsigned fail_count;

  // filter state as the block should hold it
  logic [DIM_W-1:0]   width_reg = DIM_W'(1024);
  logic [DIM_W-1:0]   height_reg = DIM_W'(1024);
  logic [LIMIT_W-1:0] limit_reg = LIMIT_W'(4);
  bit                 row_above [MAX_WIDTH];
  bit                 row_centre [MAX_WIDTH];
  logic [8:0]         win;
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [TOTAL_W-1:0] marked_sum = '0;

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned cap);
    if (v == '0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  // window bits 0..2 left column, 3..5 centre, 6..8 right; bit 0 of each column is the top row
  function automatic result_t grade_window(logic [8:0] w, logic last_col, logic last_row);
    result_t r;
    int unsigned n;
    n = 0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) n += w[i];
    end
    if (!w[4]) n = 0;
    r.marked = w[4] && (n < limit_reg);
    if (r.marked && marked_sum != TOTAL_MAX) marked_sum++;
    r.count      = CNT_W'(n);
    r.total      = marked_sum;
    r.row_done   = last_col;
    r.frame_done = last_row;
    return r;
  endfunction

  task automatic apply_cell(logic occ);
    int unsigned w, h, c, r;
    logic cur, top, mid;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    r = (row_pos > h) ? h : row_pos;
    if (c == 0) win = '0;
    // trailing row reads as empty whatever it carries
    cur = (r < h) ? occ : 1'b0;
    top = (r >= 2) ? row_above[c] : 1'b0;
    mid = (r >= 1) ? row_centre[c] : 1'b0;
    row_above[c]  = row_centre[c];
    row_centre[c] = cur;
    win = {cur, mid, top, win[8:3]};
    if (r >= 1 && c >= 1) due_results = {due_results, grade_window(win, 1'b0, 1'b0)};
    if (c == w - 1) begin
      if (r >= 1)
        due_results = {due_results, grade_window({3'b000, win[8:3]}, 1'b1, r == h)};
      col_pos = 0;
      if (r >= h) begin
        row_pos    = 0;
        marked_sum = '0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // cell source
  always @(posedge clk_i) begin : cell_driver
    int unsigned src_gap;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_cell(s_axis_tdata[0]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (cell_feed.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'b0, cell_feed.pop_front()};
          if (gaps_on && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 7);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink and checker
  always @(posedge clk_i) begin : result_monitor
    result_t want;
    int unsigned sink_hold;
    int unsigned results_seen;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          log_failure($sformatf("unexpected result tdata=%h tlast=%b tuser=%b",
                                m_axis_tdata, m_axis_tlast, m_axis_tuser));
        end else begin
          want = due_results.pop_front();
          if (m_axis_tdata[0] !== want.marked || m_axis_tdata[4:1] !== want.count ||
              m_axis_tdata[25:5] !== want.total || m_axis_tlast !== want.row_done ||
              m_axis_tuser !== want.frame_done)
            log_failure($sformatf({"result %0d: expected mark=%0d cnt=%0d total=%0d ",
                                   "row=%0d frame=%0d, got mark=%0d cnt=%0d total=%0d ",
                                   "row=%0d frame=%0d"}, results_seen,
                                  want.marked, want.count, want.total, want.row_done,
                                  want.frame_done, m_axis_tdata[0], m_axis_tdata[4:1],
                                  m_axis_tdata[25:5], m_axis_tlast, m_axis_tuser));
        end
        results_seen++;
      end
      if (long_hold_armed) begin
        long_hold_armed = 1'b0;
        sink_hold = LONG_HOLD;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        sink_hold = $urandom_range(1, 7) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_binary_neighbour_count_filter_top NOT OK");
    $finish;
  end

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= DIM_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:  width_reg = DIM_W'(val);
      REG_GRID_HEIGHT: height_reg = DIM_W'(val);
      REG_COUNT_LIMIT: limit_reg = LIMIT_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_grid(int unsigned w, int unsigned h, int unsigned lim);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_COUNT_LIMIT, lim);
  endtask

  task automatic queue_cells(int unsigned n, int unsigned density);
    @(negedge clk_i);
    repeat (n) cell_feed = {cell_feed, bit'($urandom_range(0, 99) < density)};
  endtask

  task automatic queue_pattern(logic [31:0] bits, int unsigned n);
    @(negedge clk_i);
    for (int i = 0; i < n; i++) cell_feed = {cell_feed, bit'(bits[i])};
  endtask

  // block idle: every cell taken, every result back, plus room for cells that give none
  task automatic drain();
    do @(negedge clk_i);
    while (cell_feed.size() != 0 || s_axis_tvalid || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_dim(int unsigned top);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 0;
    if (sel <= 7) return $urandom_range(1, 6);
    return $urandom_range(7, top);
  endfunction

  function automatic int unsigned pick_density();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 100;
      default: return $urandom_range(10, 90);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned w, h, n, spent;
    gaps_on = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // solid 3x3: corners, edges and centre all differ; trailing row carries ones
    set_grid(3, 3, 4);
    queue_cells(12, 100);
    drain();
    // zero sizes act as a single cell, limit above eight marks any occupied cell
    set_grid(0, 0, 15);
    queue_pattern(32'b11, 2);
    drain();
    write_reg(REG_COUNT_LIMIT, 0);
    queue_pattern(32'b11, 2);
    drain();
    // empty centre in the corner
    set_grid(2, 2, 10);
    queue_pattern(32'b111110, 6);
    drain();

    // random frames; some stop part way so the next sizes apply mid-frame
    spent = 0;
    while (spent < RANDOM_CELLS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      w = pick_dim(40);
      h = pick_dim(12);
      set_grid(w, h, $urandom_range(0, 2047));
      n = eff_dim(DIM_W'(w), MAX_WIDTH) * (eff_dim(DIM_W'(h), MAX_HEIGHT) + 1);
      if (n > 1 && $urandom_range(0, 4) == 0) n = $urandom_range(1, n - 1);
      if (n > RANDOM_CELLS - spent) n = RANDOM_CELLS - spent;
      queue_cells(n, pick_density());
      spent += n;
      drain();
    end

    // one column of a grid above the height limit, left open; the sink stalls
    // long enough to back up the input
    gaps_on = 1'b1;
    set_grid(1, 2047, 15);
    queue_cells(60, 60);
    long_hold_armed = 1'b1;
    drain();
    // widest rows, no idling: the open frame falls into its trailing row and ends
    gaps_on = 1'b0;
    set_grid(2047, 0, 9);
    queue_cells(1024, 50);
    drain();

    if (due_results.size() != 0) log_failure("results still outstanding at end of run");
    if (fail_count == 0) $display("tb_binary_neighbour_count_filter_top OK");
    else $display("tb_binary_neighbour_count_filter_top NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/bncf_pkg.sv
design/bncf_line_ram.sv
design/bncf_window.sv
design/bncf_out_fifo.sv
design/binary_neighbour_count_filter_top.sv
design/bncf_checker.sv
dv/tb_binary_neighbour_count_filter_top.sv
